// ===== sv/ffd_pkg.sv =====
// Shared types and constants for the fixed frame deframer.
`default_nettype none
package ffd_pkg;

  localparam int FRAME_BYTES = 12;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 16;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_TAIL_FIRST    = 2'd2,
    CFG_TAIL_SECOND   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    word_t device_type;
    word_t command;
    word_t payload;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/ffd_cell.sv =====
// One byte cell of the frame window shift chain.
`default_nettype none
module ffd_cell (
  input  wire logic          clk,
  input  wire logic          shift,
  input  wire ffd_pkg::byte_t din,
  output ffd_pkg::byte_t     q
);
  import ffd_pkg::*;

  byte_t data;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= din;
    end
  end

  assign q = data;

endmodule
`default_nettype wire

// ===== sv/ffd_out_buf.sv =====
// Output register with a skid entry for decoded frame results.
`default_nettype none
module ffd_out_buf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            res_valid,
  input  wire ffd_pkg::result_t res,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ffd_pkg::result_t     out_res
);
  import ffd_pkg::*;

  logic    skid_valid;
  result_t skid;
  logic    out_pop;

  assign out_pop = out_valid && !out_stall;
  assign full    = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // No input transaction is taken while the skid entry is occupied.
      if (out_pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_pop) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_res <= skid;
      end
    end else if (!out_valid || out_pop) begin
      if (res_valid) begin
        out_res <= res;
      end
    end else if (res_valid) begin
      skid <= res;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fixed_frame_deframer.sv =====
// Top level of the fixed frame deframer: cell chain, frame check and output buffer.
//
// The block finds 12-byte frames in a stream of received serial bytes.
// Input channel: rx_byte with valid/stall; one byte is taken in each cycle in
// which valid is high and stall is low; any cycle with stall low can take a byte.
// Each byte shifts into a chain of twelve byte cells. When twelve bytes are
// held, the header (bytes 0-1) and tail (bytes 10-11) are compared with the
// configuration registers in the same cycle the last byte arrives. A match
// consumes the frame; if the checksum in bytes 8-9 equals command plus payload,
// one result transaction carrying device_type, command and payload is written to
// the output register, or to the skid entry while it is stalled. A mismatch
// drops the oldest byte. Throughput is one byte per cycle while stall is low.
// The output register has a skid entry behind it, so the input keeps flowing
// while one result waits; the input is stalled only while both entries are
// occupied. Reset (rst, synchronous) clears the fill count, the output buffer's
// valid flags and the four configuration registers to zero. Configuration
// writes (cfg_we, cfg_index, cfg_data) take effect at the next clock edge.
`default_nettype none
module fixed_frame_deframer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire ffd_pkg::cfg_idx_t cfg_index,
  input  wire ffd_pkg::byte_t    cfg_data,
  input  wire logic              valid,
  output logic                   stall,
  input  wire ffd_pkg::byte_t    rx_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ffd_pkg::word_t         device_type,
  output ffd_pkg::word_t         command,
  output ffd_pkg::word_t         payload
);
  import ffd_pkg::*;

  byte_t   header_first;
  byte_t   header_second;
  byte_t   tail_first;
  byte_t   tail_second;
  cnt_t    fill_count;
  cnt_t    fill_count_next;
  cnt_t    fill_inc;
  logic    accept;
  logic    buf_full;
  logic    frame_match;
  logic    res_valid;
  result_t res;
  result_t out_res;
  word_t   checksum;
  byte_t   cell_q [FRAME_BYTES];
  byte_t   cell_d [FRAME_BYTES];

  assign stall  = buf_full;
  assign accept = valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= '0;
      header_second <= '0;
      tail_first    <= '0;
      tail_second   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_FIRST:  header_first  <= cfg_data;
        CFG_HEADER_SECOND: header_second <= cfg_data;
        CFG_TAIL_FIRST:    tail_first    <= cfg_data;
        CFG_TAIL_SECOND:   tail_second   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The newest byte enters the last cell; cell k holds frame offset k once the
  // chain is full, so after a shift frame offset k is the current cell k+1.
  genvar gi;
  generate
    for (gi = 0; gi < FRAME_BYTES; gi++) begin : g_cell
      if (gi == FRAME_BYTES - 1) begin : g_last
        assign cell_d[gi] = rx_byte;
      end else begin : g_mid
        assign cell_d[gi] = cell_q[gi+1];
      end
      ffd_cell u_cell (
        .clk   (clk),
        .shift (accept),
        .din   (cell_d[gi]),
        .q     (cell_q[gi])
      );
    end
  endgenerate

  assign frame_match = (cell_d[0] == header_first) && (cell_d[1] == header_second) &&
                       (cell_d[FRAME_BYTES-2] == tail_first) &&
                       (cell_d[FRAME_BYTES-1] == tail_second);

  assign res.device_type = {cell_d[3], cell_d[2]};
  assign res.command     = {cell_d[5], cell_d[4]};
  assign res.payload     = {cell_d[7], cell_d[6]};
  assign checksum        = {cell_d[9], cell_d[8]};

  assign fill_inc = fill_count + cnt_t'(1);

  always_comb begin
    fill_count_next = fill_count;
    res_valid       = 1'b0;
    if (accept) begin
      if (fill_inc == cnt_t'(FRAME_BYTES)) begin
        if (frame_match) begin
          fill_count_next = '0;
          res_valid       = (checksum == word_t'(res.command + res.payload));
        end else begin
          fill_count_next = cnt_t'(FRAME_BYTES - 1);
        end
      end else begin
        fill_count_next = fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  ffd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign device_type = out_res.device_type;
  assign command     = out_res.command;
  assign payload     = out_res.payload;

endmodule
`default_nettype wire
